>>> design/lppd_pkg.sv
// shared types and constants of the length-prefixed packet deframer
// no dependencies; every other file takes its names from here
package lppd_pkg;

    localparam logic [15:0] MAGIC_RESET  = 16'd12345;
    localparam logic [15:0] HEADER_BYTES = 16'd8;

    typedef enum logic [1:0] {
        ST_PAYLOAD    = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_BAD_MAGIC  = 2'd2,
        ST_BAD_LENGTH = 2'd3
    } t_status;

    // header byte positions, then payload
    typedef enum logic [3:0] {
        S_MAGIC_HI,
        S_MAGIC_LO,
        S_LEN_HI,
        S_LEN_LO,
        S_SEQ3,
        S_SEQ2,
        S_SEQ1,
        S_SEQ0,
        S_PAYLOAD
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [7:0]  payload_byte;
        logic [31:0] sequence_res;
        logic [15:0] payload_index;
        logic        last;
    } t_result;

endpackage

>>> design/lppd_if.sv
// stream channel interfaces of the deframer: received bytes in, results out
// depends on lppd_pkg for the result fields
interface lppd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lppd_out_if;
    logic                 valid;
    logic                 ready;
    lppd_pkg::t_status    status;
    logic [7:0]           payload_byte;
    logic [31:0]          sequence_res;
    logic [15:0]          payload_index;
    logic                 last;

    modport source (output valid, output status, output payload_byte,
                    output sequence_res, output payload_index, output last,
                    input ready);
    modport sink   (input valid, input status, input payload_byte,
                    input sequence_res, input payload_index, input last,
                    output ready);
endinterface

>>> design/lppd_parser.sv
// header parser and payload counter: one byte per accepted transfer
// depends on lppd_pkg
module lppd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic [15:0]       i_expected_magic,
    output logic              o_res_valid,
    output lppd_pkg::t_result o_res
);

    lppd_pkg::t_state r_state, n_state;
    logic [7:0]  r_magic_hi, n_magic_hi;
    logic [15:0] r_length, n_length;
    logic [31:0] r_seq, n_seq;
    logic [15:0] r_count, n_count;

    logic [15:0] w_length;
    logic [16:0] w_total;
    logic [16:0] w_next_idx;
    logic        w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lppd_pkg::S_MAGIC_HI;
            r_magic_hi <= '0;
            r_length   <= '0;
            r_seq      <= '0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_magic_hi <= n_magic_hi;
            r_length   <= n_length;
            r_seq      <= n_seq;
            r_count    <= n_count;
        end
    end

    assign w_length   = {r_length[15:8], i_byte};
    assign w_total    = {1'b0, r_length} - {1'b0, lppd_pkg::HEADER_BYTES};
    assign w_next_idx = {1'b0, r_count} + 17'd1;
    assign w_last     = (w_next_idx >= w_total);

    always_comb begin
        n_state     = r_state;
        n_magic_hi  = r_magic_hi;
        n_length    = r_length;
        n_seq       = r_seq;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            unique case (r_state)
                lppd_pkg::S_MAGIC_HI: begin
                    n_magic_hi = i_byte;
                    n_state    = lppd_pkg::S_MAGIC_LO;
                end
                lppd_pkg::S_MAGIC_LO: begin
                    if ({r_magic_hi, i_byte} != i_expected_magic) begin
                        o_res_valid  = 1'b1;
                        o_res.status = lppd_pkg::ST_BAD_MAGIC;
                        o_res.last   = 1'b1;
                        n_state      = lppd_pkg::S_MAGIC_HI;
                    end else begin
                        n_state = lppd_pkg::S_LEN_HI;
                    end
                end
                lppd_pkg::S_LEN_HI: begin
                    n_length = {i_byte, r_length[7:0]};
                    n_state  = lppd_pkg::S_LEN_LO;
                end
                lppd_pkg::S_LEN_LO: begin
                    n_length = w_length;
                    if (w_length < lppd_pkg::HEADER_BYTES) begin
                        o_res_valid  = 1'b1;
                        o_res.status = lppd_pkg::ST_BAD_LENGTH;
                        o_res.last   = 1'b1;
                        n_state      = lppd_pkg::S_MAGIC_HI;
                    end else begin
                        n_state = lppd_pkg::S_SEQ3;
                    end
                end
                lppd_pkg::S_SEQ3: begin
                    n_seq   = {i_byte, r_seq[23:0]};
                    n_state = lppd_pkg::S_SEQ2;
                end
                lppd_pkg::S_SEQ2: begin
                    n_seq   = {r_seq[31:24], i_byte, r_seq[15:0]};
                    n_state = lppd_pkg::S_SEQ1;
                end
                lppd_pkg::S_SEQ1: begin
                    n_seq   = {r_seq[31:16], i_byte, r_seq[7:0]};
                    n_state = lppd_pkg::S_SEQ0;
                end
                lppd_pkg::S_SEQ0: begin
                    n_seq   = {r_seq[31:8], i_byte};
                    n_count = '0;
                    if (r_length == lppd_pkg::HEADER_BYTES) begin
                        // header-only packet
                        o_res_valid        = 1'b1;
                        o_res.status       = lppd_pkg::ST_EMPTY;
                        o_res.sequence_res = {r_seq[31:8], i_byte};
                        o_res.last         = 1'b1;
                        n_state            = lppd_pkg::S_MAGIC_HI;
                    end else begin
                        n_state = lppd_pkg::S_PAYLOAD;
                    end
                end
                lppd_pkg::S_PAYLOAD: begin
                    o_res_valid         = 1'b1;
                    o_res.status        = lppd_pkg::ST_PAYLOAD;
                    o_res.payload_byte  = i_byte;
                    o_res.sequence_res  = r_seq;
                    o_res.payload_index = r_count;
                    o_res.last          = w_last;
                    n_count             = w_next_idx[15:0];
                    if (w_last) begin
                        n_state = lppd_pkg::S_MAGIC_HI;
                    end
                end
                default: begin
                    n_state = lppd_pkg::S_MAGIC_HI;
                end
            endcase
        end
    end

endmodule

>>> design/lppd_out_reg.sv
// result register that drives the output channel and sets input flow control
// depends on lppd_pkg and lppd_if
module lppd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lppd_pkg::t_result i_res,
    output logic              o_take,
    lppd_out_if.source        o_res
);

    logic              r_valid, n_valid;
    lppd_pkg::t_result r_res;

    // room for a new result when empty or when the held one leaves now
    assign o_take = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.status        = r_res.status;
    assign o_res.payload_byte  = r_res.payload_byte;
    assign o_res.sequence_res  = r_res.sequence_res;
    assign o_res.payload_index = r_res.payload_index;
    assign o_res.last          = r_res.last;

endmodule

>>> design/length_prefixed_packet_deframer_top.sv
// top level of the length-prefixed packet deframer
// depends on lppd_pkg, lppd_if, lppd_parser and lppd_out_reg
//
//   channel   dir  handshake        payload
//   i_rx      in   valid / ready    rx_byte[7:0]
//   o_res     out  valid / ready    status, payload_byte, sequence_res,
//                                   payload_index, last
//   cfg       in   i_cfg_we         i_cfg_wdata[15:0] (expected magic)
//
// one byte per cycle while ready is high; a byte that gives a result shows it on o_res
// the cycle after its transfer, registered in the result register
// ready is high while the result register is empty or being emptied, so a
// stalled output holds back the input only when a result is still waiting
// synchronous active-low reset starts header collection and loads the
// default magic; no clearing pass
module length_prefixed_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    lppd_in_if.sink     i_rx,
    lppd_out_if.source  o_res
);

    // expected magic register
    logic [15:0] r_expected_magic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic <= lppd_pkg::MAGIC_RESET;
        end else if (i_cfg_we) begin
            r_expected_magic <= i_cfg_wdata;
        end
    end

    logic              w_take;
    logic              w_accept;
    logic              w_res_valid;
    lppd_pkg::t_result w_res;

    assign i_rx.ready = w_take;
    assign w_accept   = i_rx.valid && w_take;

    // header fields and payload counting
    lppd_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_byte           (i_rx.rx_byte),
        .i_expected_magic (r_expected_magic),
        .o_res_valid      (w_res_valid),
        .o_res            (w_res)
    );

    // result register toward the consumer
    lppd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_take  (w_take),
        .o_res   (o_res)
    );

    // every result other than a payload byte closes a packet or header attempt
    a_nonpayload_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != lppd_pkg::ST_PAYLOAD) |-> o_res.last)
        else $error("non-payload result without last");

    // only payload results carry a byte or an index
    a_nonpayload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != lppd_pkg::ST_PAYLOAD)
        |-> (o_res.payload_byte == 8'd0 && o_res.payload_index == 16'd0))
        else $error("non-payload result with byte or index");

    // error results come before any sequence number is known
    a_error_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == lppd_pkg::ST_BAD_MAGIC ||
                         o_res.status == lppd_pkg::ST_BAD_LENGTH))
        |-> (o_res.sequence_res == 32'd0))
        else $error("error result with sequence number");

    // a transfer while a result waits unaccepted would overwrite it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !w_res_valid)
        else $error("result produced while output stalled");

endmodule
